// ----- rtl/ray_cone_intersect_unit_defines.svh -----
// Assertion macros shared by the checker of the ray/cone intersection unit.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RAY_CONE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_CONE_INTERSECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCI_CHECK_IMPL(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("rci check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCI_CHECK_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("rci check failed");

// Property that must hold at every edge while reset is asserted.
`define RCI_CHECK_RESET(label, prop) \
	label: assert property (@(posedge clk) (!arst_n) |-> (prop)) \
		else $error("rci check failed");

`endif

// ----- rtl/rci_pkg.sv -----
// Shared types and constants of the ray/cone intersection unit.
// No dependencies; every other file of the unit but the assertion macros header imports this package.
`default_nettype none

package rci_pkg;

	// Fixed-point format and threshold register.
	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 17;

	// Offsets are clipped to 2^CAP_LOG, so the quotient needs CAP_LOG+1 bits.
	localparam int CAP_LOG = 40;
	localparam int QBITS   = CAP_LOG + 1;

	// Square root: 128-bit radicand, 64-bit root.
	localparam int ROOT_W = 64;
	localparam int RAD_W  = 2 * ROOT_W;

	// Depth of the decoupling queues.
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// One input word: ray origin and direction, signed Q16.16.
	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} in_word_t;

	// One result word.
	typedef struct packed {
		logic               is_hit;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} out_word_t;

	// Sideband carried alongside the square root pipeline.
	typedef struct packed {
		in_word_t           ray;
		logic        [63:0] a;
		logic signed [63:0] h;
		logic               live;
	} sqrt_side_t;

	// Word passed from the front part to the back part.
	typedef struct packed {
		in_word_t    ray;
		logic [63:0] a;
		logic [63:0] n;
		logic        hit;
	} mid_word_t;

endpackage

`default_nettype wire

// ----- rtl/rci_fifo.sv -----
// Small register queue used to decouple pipeline sections.
// Depends on rci_pkg for the queue depth.
`default_nettype none

module rci_fifo
	import rci_pkg::*;
#(
	parameter int WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] dout
);

	logic [WIDTH-1:0]   mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// Storage for queued words.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

`default_nettype wire

// ----- rtl/rci_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, rounded down.
// Depends on rci_pkg for widths and the sideband type.
`default_nettype none

module rci_sqrt
	import rci_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [RAD_W-1:0]  in_rad,
	input  wire sqrt_side_t        in_side,
	output logic                   out_valid,
	output logic      [ROOT_W-1:0] out_root,
	output sqrt_side_t             out_side
);

	logic              vld_q  [ROOT_W];
	logic [RAD_W-1:0]  res_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];
	sqrt_side_t        side_q [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;

		logic              vld_i;
		logic [RAD_W-1:0]  res_i;
		logic [ROOT_W-1:0] root_i;
		sqrt_side_t        side_i;
		logic [RAD_W+1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign res_i  = in_rad;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_q[k-1];
			assign res_i  = res_q[k-1];
			assign root_i = root_q[k-1];
			assign side_i = side_q[k-1];
		end

		// Trial subtrahend (2*root + 2^B) * 2^B; root has no bits at or below B.
		assign trial = ({(RAD_W + 2 - ROOT_W)'(0), root_i} << (B + 1))
			| ((RAD_W + 2)'(1) << (2 * B));
		assign take  = {2'b00, res_i} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[k] <= 1'b0;
			else if (en) vld_q[k] <= vld_i;
		end

		// Accept the root bit when the residual covers the trial value.
		always_ff @(posedge clk) begin
			if (en) begin
				res_q[k]  <= take ? res_i - trial[RAD_W-1:0] : res_i;
				root_q[k] <= take ? root_i | (ROOT_W'(1) << B) : root_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_q[ROOT_W-1];
	assign out_root  = root_q[ROOT_W-1];
	assign out_side  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/rci_front.sv -----
// Front part: quadratic coefficients, discriminant, square root and root choice.
// Depends on rci_pkg and rci_sqrt.
`default_nettype none

module rci_front
	import rci_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CFG_W-1:0] min_coeff,
	input  wire logic             push,
	output logic                  full,
	input  wire in_word_t         ray,
	output logic                  out_push,
	input  wire logic             out_full,
	output mid_word_t             out_word
);

	logic en;
	logic acc;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [63:0] p_uu_s1, p_vv_s1, p_ww_s1;
	logic signed [63:0] p_xu_s1, p_yv_s1, p_zw_s1;
	logic signed [63:0] p_xx_s1, p_yy_s1, p_zz_s1;
	in_word_t           ray_s1;

	logic signed [63:0] a_s2, h_s2, c_s2;
	in_word_t           ray_s2;

	logic [63:0]        mag_h, mag_c;
	logic [66:0]        a8, thr;
	logic [63:0]        hh_ll_s3, hh_lh_s3, hh_hh_s3;
	logic [63:0]        ac_ll_s3, ac_lh_s3, ac_hl_s3, ac_hh_s3;
	logic               live_s3, cneg_s3;
	logic [63:0]        a_s3;
	logic signed [63:0] h_s3;
	in_word_t           ray_s3;

	logic [RAD_W-1:0]   hh_s4, ac_s4;
	logic               live_s4, cneg_s4;
	logic [63:0]        a_s4;
	logic signed [63:0] h_s4;
	in_word_t           ray_s4;

	logic [RAD_W-1:0]   disc_s5;
	sqrt_side_t         side_s5;

	logic               sq_valid;
	logic [ROOT_W-1:0]  sq_root;
	sqrt_side_t         sq_side;
	logic signed [63:0] s_sg, n_near, n_far, n_sel;

	mid_word_t          word_s6;

	// The whole section advances together unless its last word is blocked.
	assign en       = !(vld_s6 && out_full);
	assign full     = !en;
	assign acc      = push && en;
	assign out_push = vld_s6 && !out_full;
	assign out_word = word_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= sq_valid;
		end
	end

	// Stage 1: the nine exact 32x32 products.
	always_ff @(posedge clk) begin
		if (en) begin
			p_uu_s1 <= ray.dir_x * ray.dir_x;
			p_vv_s1 <= ray.dir_y * ray.dir_y;
			p_ww_s1 <= ray.dir_z * ray.dir_z;
			p_xu_s1 <= ray.origin_x * ray.dir_x;
			p_yv_s1 <= ray.origin_y * ray.dir_y;
			p_zw_s1 <= ray.origin_z * ray.dir_z;
			p_xx_s1 <= ray.origin_x * ray.origin_x;
			p_yy_s1 <= ray.origin_y * ray.origin_y;
			p_zz_s1 <= ray.origin_z * ray.origin_z;
			ray_s1  <= ray;
		end
	end

	// Stage 2: coefficients from quartered products, floor rounding.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= (p_uu_s1 >>> 2) + (p_ww_s1 >>> 2) - (p_vv_s1 >>> 2);
			h_s2   <= (p_xu_s1 >>> 2) + (p_zw_s1 >>> 2) - (p_yv_s1 >>> 2);
			c_s2   <= (p_xx_s1 >>> 2) + (p_zz_s1 >>> 2) - (p_yy_s1 >>> 2);
			ray_s2 <= ray_s1;
		end
	end

	// Stage 3: threshold test and 32x32 partial products of h*h and a*|c|.
	assign mag_h = h_s2[63] ? 64'(-h_s2) : 64'(h_s2);
	assign mag_c = c_s2[63] ? 64'(-c_s2) : 64'(c_s2);
	assign a8    = {a_s2, 3'b000};
	assign thr   = {(67 - CFG_W)'(0), min_coeff} << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			hh_ll_s3 <= mag_h[31:0] * mag_h[31:0];
			hh_lh_s3 <= mag_h[31:0] * mag_h[63:32];
			hh_hh_s3 <= mag_h[63:32] * mag_h[63:32];
			ac_ll_s3 <= a_s2[31:0] * mag_c[31:0];
			ac_lh_s3 <= a_s2[31:0] * mag_c[63:32];
			ac_hl_s3 <= a_s2[63:32] * mag_c[31:0];
			ac_hh_s3 <= a_s2[63:32] * mag_c[63:32];
			live_s3  <= (a_s2 > 64'sd0) && !(a8 < thr);
			cneg_s3  <= c_s2[63];
			a_s3     <= a_s2;
			h_s3     <= h_s2;
			ray_s3   <= ray_s2;
		end
	end

	// Stage 4: assemble the 128-bit products.
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s4   <= {64'd0, hh_ll_s3} + {31'd0, hh_lh_s3, 33'd0} + {hh_hh_s3, 64'd0};
			ac_s4   <= {64'd0, ac_ll_s3} + {32'd0, ac_lh_s3, 32'd0}
				+ {32'd0, ac_hl_s3, 32'd0} + {ac_hh_s3, 64'd0};
			live_s4 <= live_s3;
			cneg_s4 <= cneg_s3;
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			ray_s4  <= ray_s3;
		end
	end

	// Stage 5: discriminant h*h - a*c; a negative one is a miss.
	always_ff @(posedge clk) begin
		if (en) begin
			disc_s5      <= cneg_s4 ? hh_s4 + ac_s4 : hh_s4 - ac_s4;
			side_s5.live <= live_s4 && (cneg_s4 || (hh_s4 >= ac_s4));
			side_s5.a    <= a_s4;
			side_s5.h    <= h_s4;
			side_s5.ray  <= ray_s4;
		end
	end

	rci_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.in_rad    (disc_s5),
		.in_side   (side_s5),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// Stage 6: nearer root when positive, else the farther one.
	assign s_sg   = signed'(sq_root);
	assign n_near = -sq_side.h - s_sg;
	assign n_far  = s_sg - sq_side.h;
	assign n_sel  = (n_near > 64'sd0) ? n_near : n_far;

	always_ff @(posedge clk) begin
		if (en) begin
			word_s6.ray <= sq_side.ray;
			word_s6.a   <= sq_side.a;
			word_s6.n   <= 64'(n_sel);
			word_s6.hit <= sq_side.live && !n_sel[63];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rci_back.sv -----
// Back part: offsets dir*n/a per axis, clipping, and the saturated hit point.
// Depends on rci_pkg.
`default_nettype none

module rci_back
	import rci_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire mid_word_t in_word,
	output logic           in_pop,
	input  wire logic      out_full,
	output logic           out_push,
	output out_word_t      out_word
);

	localparam logic [QBITS-1:0] CAP = QBITS'(1) << CAP_LOG;

	// Per-axis sideband that rides along the divider.
	typedef struct packed {
		logic               ovf;
		logic               neg;
		logic signed [31:0] o;
	} lane_t;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_f;

	logic signed [31:0] o_in [3];
	logic signed [31:0] d_in [3];
	logic        [31:0] d_mag [3];

	logic [63:0]        plo_s1 [3];
	logic [63:0]        phi_s1 [3];
	logic               neg_s1 [3];
	logic signed [31:0] o_s1 [3];
	logic [63:0]        a_s1;
	logic               hit_s1;

	logic [95:0]        num_s2 [3];
	logic               neg_s2 [3];
	logic signed [31:0] o_s2 [3];
	logic [63:0]        a_s2;
	logic               hit_s2;

	logic [63:0]        rem_s3 [3];
	logic [QBITS-1:0]   low_s3 [3];
	lane_t              lane_s3 [3];
	logic [63:0]        a_s3;
	logic               hit_s3;

	logic               vld_q  [QBITS];
	logic [63:0]        a_q    [QBITS];
	logic               hit_q  [QBITS];
	logic [63:0]        rem_q  [QBITS][3];
	logic [QBITS-1:0]   quo_q  [QBITS][3];
	logic [QBITS-1:0]   low_q  [QBITS][3];
	lane_t              lane_q [QBITS][3];

	logic [QBITS-1:0]   off [3];
	logic signed [42:0] sum [3];
	logic signed [31:0] sat [3];

	out_word_t          word_f;

	// The section advances together unless its last word is blocked.
	assign en       = !(vld_f && out_full);
	assign in_pop   = en && in_valid;
	assign out_push = vld_f && !out_full;
	assign out_word = word_f;

	assign o_in[0] = in_word.ray.origin_x;
	assign o_in[1] = in_word.ray.origin_y;
	assign o_in[2] = in_word.ray.origin_z;
	assign d_in[0] = in_word.ray.dir_x;
	assign d_in[1] = in_word.ray.dir_y;
	assign d_in[2] = in_word.ray.dir_z;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			d_mag[l] = d_in[l][31] ? 32'(-d_in[l]) : 32'(d_in[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_f  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_f  <= vld_q[QBITS-1];
		end
	end

	// Stage 1: partial products of |d| * n.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				plo_s1[l] <= d_mag[l] * in_word.n[31:0];
				phi_s1[l] <= d_mag[l] * in_word.n[63:32];
				neg_s1[l] <= d_in[l][31];
				o_s1[l]   <= o_in[l];
			end
			a_s1   <= in_word.a;
			hit_s1 <= in_word.hit;
		end
	end

	// Stage 2: full 96-bit dividend.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				num_s2[l] <= {32'd0, plo_s1[l]} + {phi_s1[l], 32'd0};
				neg_s2[l] <= neg_s1[l];
				o_s2[l]   <= o_s1[l];
			end
			a_s2   <= a_s1;
			hit_s2 <= hit_s1;
		end
	end

	// Stage 3: a quotient of 2^QBITS or more is clipped; otherwise the
	// upper dividend bits form the starting remainder, already below a.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s3[l]      <= {(64 - (96 - QBITS))'(0), num_s2[l][95:QBITS]};
				low_s3[l]      <= num_s2[l][QBITS-1:0];
				lane_s3[l].ovf <= {(64 - (96 - QBITS))'(0), num_s2[l][95:QBITS]} >= a_s2;
				lane_s3[l].neg <= neg_s2[l];
				lane_s3[l].o   <= o_s2[l];
			end
			a_s3   <= a_s2;
			hit_s3 <= hit_s2;
		end
	end

	// Restoring divider, one quotient bit per stage, three axes side by side.
	for (genvar j = 0; j < QBITS; j++) begin : g_div
		logic             vld_i;
		logic [63:0]      a_i;
		logic             hit_i;
		logic [63:0]      rem_i  [3];
		logic [QBITS-1:0] quo_i  [3];
		logic [QBITS-1:0] low_i  [3];
		lane_t            lane_i [3];
		logic [64:0]      trial  [3];
		logic             take   [3];

		if (j == 0) begin : g_first
			assign vld_i = vld_s3;
			assign a_i   = a_s3;
			assign hit_i = hit_s3;
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_i[l]  = rem_s3[l];
					quo_i[l]  = '0;
					low_i[l]  = low_s3[l];
					lane_i[l] = lane_s3[l];
				end
			end
		end else begin : g_next
			assign vld_i = vld_q[j-1];
			assign a_i   = a_q[j-1];
			assign hit_i = hit_q[j-1];
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_i[l]  = rem_q[j-1][l];
					quo_i[l]  = quo_q[j-1][l];
					low_i[l]  = low_q[j-1][l];
					lane_i[l] = lane_q[j-1][l];
				end
			end
		end

		// Shift in the next dividend bit and try to subtract the divisor.
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				trial[l] = {rem_i[l], low_i[l][QBITS-1-j]};
				take[l]  = trial[l] >= {1'b0, a_i};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[j] <= 1'b0;
			else if (en) vld_q[j] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_q[j][l]  <= take[l] ? 64'(trial[l] - {1'b0, a_i}) : trial[l][63:0];
					quo_q[j][l]  <= {quo_i[l][QBITS-2:0], take[l]};
					low_q[j][l]  <= low_i[l];
					lane_q[j][l] <= lane_i[l];
				end
				a_q[j]   <= a_i;
				hit_q[j] <= hit_i;
			end
		end
	end

	// Final stage: clip the offset, apply the sign, add and saturate.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			off[l] = (lane_q[QBITS-1][l].ovf || (quo_q[QBITS-1][l] > CAP))
				? CAP : quo_q[QBITS-1][l];
			sum[l] = lane_q[QBITS-1][l].neg
				? 43'(lane_q[QBITS-1][l].o) - signed'({2'b00, off[l]})
				: 43'(lane_q[QBITS-1][l].o) + signed'({2'b00, off[l]});
			if (sum[l] > 43'sd2147483647) sat[l] = 32'sh7fffffff;
			else if (sum[l] < -43'sd2147483648) sat[l] = 32'sh80000000;
			else sat[l] = sum[l][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_f.is_hit <= hit_q[QBITS-1];
			word_f.hit_x  <= hit_q[QBITS-1] ? sat[0] : 32'sd0;
			word_f.hit_y  <= hit_q[QBITS-1] ? sat[1] : 32'sd0;
			word_f.hit_z  <= hit_q[QBITS-1] ? sat[2] : 32'sd0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ray_cone_intersect_unit.sv -----
// Ray versus double cone x^2 + z^2 = y^2 intersection unit, Q16.16 in and out.
// The unit takes one ray word per clock unless full, and delivers one result word per
// ray in order. A ray passes through a 70-stage front section (products, coefficients,
// discriminant, a 64-stage square root at one root bit per stage, root choice),
// the middle queue, and a 45-stage back section (offset products, a 41-stage
// divider at one quotient bit per stage, clipping and saturation), with a
// four-word queue between the sections and another at the output. The square root
// and the divider set the latency; throughput is one word per clock while results
// are popped.
// Depends on rci_pkg, rci_front, rci_back and rci_fifo.
`default_nettype none

module ray_cone_intersect_unit
	import rci_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire in_word_t         ray,
	output logic                  empty,
	input  wire logic             pop,
	output out_word_t             result,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] min_coeff_q;

	logic      mid_push, mid_full, mid_pop, mid_empty;
	mid_word_t mid_in, mid_out;
	logic      res_push, res_full;
	out_word_t res_in;

	// Leading-coefficient threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_coeff_q <= CFG_W'(1);
		else if (cfg_we) min_coeff_q <= cfg_data;
	end

	rci_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_coeff (min_coeff_q),
		.push      (push),
		.full      (full),
		.ray       (ray),
		.out_push  (mid_push),
		.out_full  (mid_full),
		.out_word  (mid_in)
	);

	rci_fifo #(.WIDTH($bits(mid_word_t))) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.din    (mid_in),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.dout   (mid_out)
	);

	rci_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_word  (mid_out),
		.in_pop   (mid_pop),
		.out_full (res_full),
		.out_push (res_push),
		.out_word (res_in)
	);

	rci_fifo #(.WIDTH($bits(out_word_t))) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

endmodule

`default_nettype wire

// ----- rtl/rci_checker.sv -----
// Port-level checker for the ray/cone intersection unit, bound to the top level.
// Depends on rci_pkg and the assertion macros header.
`default_nettype none

`include "ray_cone_intersect_unit_defines.svh"

module rci_checker
	import rci_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_word_t result
);

	// A waiting result word holds until it is popped.
	`RCI_CHECK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result))

	// A miss always reports the zero point.
	`RCI_CHECK_IMPL(a_miss_zero, !empty && !result.is_hit, result == '0)

	// While in reset nothing is queued and rays may be pushed.
	`RCI_CHECK_RESET(a_reset_idle, empty && !full)

endmodule

bind ray_cone_intersect_unit rci_checker u_rci_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

// ----- tb/ray_cone_intersect_unit_tb.sv -----
// Self-checking testbench of the ray/double cone intersection unit.
// Drives ray words, predicts every result word in order and compares it field by field.
// Depends on rci_pkg and ray_cone_intersect_unit.
`timescale 1ns / 100ps
`default_nettype none

module ray_cone_intersect_unit_tb;
	import rci_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 160;
	localparam int PHASE_RAYS     = 300;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	in_word_t         ray_word;
	logic             empty;
	logic             pop;
	out_word_t        result;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_data;

	// Predictor state and the queue of expected result words.
	logic [CFG_W-1:0] thr_copy;
	out_word_t        hit_queue[$];
	int               mismatches;
	int               idle_cycles;
	int               send_idle_pct;
	int               recv_stall_pct;

	// Directed stimulus rows; typed expectations only where obvious.
	typedef struct {
		in_word_t  word;
		bit        typed;
		out_word_t want;
	} ray_row_t;

	ray_cone_intersect_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.ray     (ray_word),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// One hit coordinate: origin plus the clipped offset, saturated to 32 bits.
	function automatic logic [31:0] hit_coord(longint o, longint d, logic [63:0] n,
			logic [63:0] a);
		logic [127:0] q;
		longint       off;
		longint       res;
		q = ({64'd0, magnitude(d)} * {64'd0, n}) / {64'd0, a};
		off = (q > (128'd1 << 40)) ? (64'sd1 <<< 40) : longint'(q[63:0]);
		res = d < 0 ? o - off : o + off;
		if (res > 64'sd2147483647)
			res = 64'sd2147483647;
		if (res < -64'sd2147483648)
			res = -64'sd2147483648;
		return res[31:0];
	endfunction

	// Full intersection of one ray with the cone under the given threshold.
	function automatic out_word_t cone_hit(in_word_t r, logic [CFG_W-1:0] thr);
		longint       x, y, z, u, v, w, a, h, c, s, n_far, n_near, n;
		logic [127:0] hh, ac, disc;
		logic [63:0]  root, cand;
		bit           hit;
		out_word_t    o;
		x = r.origin_x; y = r.origin_y; z = r.origin_z;
		u = r.dir_x; v = r.dir_y; w = r.dir_z;
		a = ((u * u) >>> 2) + ((w * w) >>> 2) - ((v * v) >>> 2);
		h = ((x * u) >>> 2) + ((z * w) >>> 2) - ((y * v) >>> 2);
		c = ((x * x) >>> 2) + ((z * z) >>> 2) - ((y * y) >>> 2);
		hit = 1'b0;
		n = 0;
		o = '0;
		if (a > 0 && !(a < (64'sd1 <<< 41) && a * 8 < (longint'(thr) <<< FRAC_BITS))) begin
			hh = {64'd0, magnitude(h)} * {64'd0, magnitude(h)};
			ac = {64'd0, 64'(a)} * {64'd0, magnitude(c)};
			if (c < 0 || hh >= ac) begin
				disc = c < 0 ? hh + ac : hh - ac;
				root = '0;
				for (int b = 63; b >= 0; b--) begin
					cand = root | (64'd1 << b);
					if ({64'd0, cand} * {64'd0, cand} <= disc)
						root = cand;
				end
				s = longint'(root);
				n_far = s - h;
				n_near = -h - s;
				n = n_near > 0 ? n_near : n_far;
				hit = n >= 0;
			end
		end
		if (hit) begin
			o.is_hit = 1'b1;
			o.hit_x = hit_coord(x, u, 64'(n), 64'(a));
			o.hit_y = hit_coord(y, v, 64'(n), 64'(a));
			o.hit_z = hit_coord(z, w, 64'(n), 64'(a));
		end
		return o;
	endfunction

	// Track the threshold and predict each accepted ray word.
	always @(posedge clk) begin
		if (cfg_we)
			thr_copy <= cfg_data;
		if (arst_n && push && !full)
			hit_queue.push_back(cone_hit(ray_word, thr_copy));
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", result);
			end else begin
				want = hit_queue.pop_front();
				if (result.is_hit !== want.is_hit || result.hit_x !== want.hit_x ||
						result.hit_y !== want.hit_y || result.hit_z !== want.hit_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %b %h %h %h, got %b %h %h %h",
							want.is_hit, want.hit_x, want.hit_y, want.hit_z,
							result.is_hit, result.hit_x, result.hit_y, result.hit_z);
				end
			end
		end
	end

	// Receiver stalls are chosen at the falling edge.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on cycles in which no word moves on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one ray word, with random sender gaps, until it is accepted.
	task automatic send_ray(in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		ray_word = w;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Stop sending, wait for every expected word, then let the pipe settle.
	task automatic drain_results();
		@(negedge clk);
		push = 1'b0;
		while (hit_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly rays near the cone, some with tiny directions, some full-range noise.
	function automatic in_word_t random_ray();
		in_word_t w;
		int       kind;
		kind = $urandom_range(9);
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (kind < 6) begin
			w.origin_x = $signed($urandom_range(20 << 16)) - (10 << 16);
			w.origin_y = $signed($urandom_range(20 << 16)) - (10 << 16);
			w.origin_z = $signed($urandom_range(20 << 16)) - (10 << 16);
			w.dir_x = $signed($urandom_range(4 << 16)) - (2 << 16);
			w.dir_y = $signed($urandom_range(4 << 16)) - (2 << 16);
			w.dir_z = $signed($urandom_range(4 << 16)) - (2 << 16);
		end else if (kind < 8) begin
			w.dir_x = $signed($urandom_range(64)) - 32;
			w.dir_y = $signed($urandom_range(64)) - 32;
			w.dir_z = $signed($urandom_range(64)) - 32;
		end
		return w;
	endfunction

	initial begin
		ray_row_t  rows[$];
		ray_row_t  row;
		int        stall_sets[4][2];
		out_word_t miss_word;
		out_word_t origin_hit;

		push = 1'b0;
		ray_word = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		pop = 1'b0;
		thr_copy = 17'd1;
		mismatches = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_sets = '{'{0, 0}, '{53, 0}, '{0, 53}, '{29, 29}};
		miss_word = '0;
		origin_hit = '0;
		origin_hit.is_hit = 1'b1;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: zero and axial directions, tiny leading terms, extremes.
		rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, miss_word});
		rows.push_back('{'{0, 0, 0, 0, 32'sh10000, 0}, 1'b1, miss_word});
		rows.push_back('{'{0, 0, 0, 32'sh10000, 0, 0}, 1'b1, origin_hit});
		rows.push_back('{'{0, 0, 0, 2, 0, 0}, 1'b0, miss_word});
		rows.push_back('{'{0, 0, 0, 1, 0, 0}, 1'b0, miss_word});
		rows.push_back('{'{32'sh30000, 32'sh50000, 0, -32'sh10000, 0, 0}, 1'b0, miss_word});
		rows.push_back('{'{0, 32'sh50000, 0, 32'sh10000, 0, 32'sh10000}, 1'b0, miss_word});
		rows.push_back('{'{32'sh10000, 0, 32'sh10000, 32'sh10000, 0, 0}, 1'b0, miss_word});
		rows.push_back('{'{-32'sh20000, 32'sh10000, 0, 32'sh10000, 32'sh8000, 0}, 1'b0,
			miss_word});
		rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff}, 1'b0, miss_word});
		rows.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000}, 1'b0, miss_word});
		rows.push_back('{'{32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, 0,
			32'sh7fffffff}, 1'b0, miss_word});
		rows.push_back('{'{0, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh10000, 0}, 1'b0,
			miss_word});
		rows.push_back('{'{32'sh7fff0000, 0, 0, 32'sh7fffffff, 0, 32'sh7fffffff}, 1'b0,
			miss_word});
		rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 1'b0, miss_word});

		// Typed rows are checked here against the predictor as well.
		foreach (rows[i]) begin
			row = rows[i];
			if (row.typed && cone_hit(row.word, thr_copy) !== row.want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: expected %h, got %h", i, row.want,
						cone_hit(row.word, thr_copy));
			end
			send_ray(row.word);
		end
		drain_results();

		// Random phases: the four idling modes in turn, with a new threshold for each phase.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_threshold(17'd0);
				1: write_threshold(17'd65536);
				2: write_threshold(17'd1);
				default: write_threshold(17'($urandom_range(65536)));
			endcase
			send_idle_pct = stall_sets[p % 4][0];
			recv_stall_pct = stall_sets[p % 4][1];
			for (int k = 0; k < PHASE_RAYS; k++)
				send_ray(random_ray());
			drain_results();
		end

		if (mismatches == 0 && hit_queue.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
